[sv/sorted_archive_insert_macros.svh]
// Assertion macros for the sorted archive insert block
`ifndef SORTED_ARCHIVE_INSERT_MACROS_SVH
`define SORTED_ARCHIVE_INSERT_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define SAI_ASSERT_IMPL(label, a, c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define SAI_ASSERT_NEXT(label, a, c, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) else $error(msg);
`endif

[sv/sai_pkg.sv]
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and codes for the sorted archive insert block.
// ----------------------------------------------------------------------------
`default_nettype none
package sai_pkg;
   localparam logic       KIND_INSERT     = 1'b0;
   localparam logic       KIND_READ       = 1'b1;
   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_EVICTED  = 2'd1;
   localparam logic [1:0] STATUS_READ     = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_WAIT, ST_EV_DIV, ST_EV_RD, ST_EV_SHIFT, ST_EV_WR,
      ST_SRCH_RD, ST_SRCH_CMP, ST_INS_RD, ST_INS_WR, ST_DONE
   } state_type;
endpackage
`default_nettype wire

[sv/sorted_archive_insert.sv]
// Read: the table entry is read, then the response is registered. Insert: a binary
//   search of at most log2(count) + 1 probes, then count - position entries moved up.
// Eviction first runs the remainder unit, reads the entry and closes up the entries after it.
// One request at a time; the next is taken once the response is registered and the
//   block is back in idle with no configuration write pending.
// Reset: synchronous; clears count, capacity to 256 and control; table undefined.
// ----------------------------------------------------------------------------
// sorted_archive_insert
// Sorted table of key/handle pairs with read by index, eviction, binary search and insert.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_archive_insert
   import sai_pkg::*;
#(
   parameter int DEPTH       = 256,
   parameter int KEY_BITS    = 32,
   parameter int HANDLE_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // kind[0], key[32:1], item_id[48:33], evict_pick[64:49], read_index[72:65]
   input  wire logic [79:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], position[9:2], count[18:10], out_key[50:19], out_id[66:51]
   output      logic [71:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [8:0]  csr_data
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int EW = KEY_BITS + HANDLE_BITS;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, cap;
   logic [8:0]    capacity_ff;
   logic          kind_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [HANDLE_BITS-1:0] id_ff;
   logic [7:0]    ridx_ff;
   logic [CW-1:0] idx_ff, idx_in, pos_ff, pos_in;
   logic signed [CW:0] low_ff, low_in, high_ff, high_in;
   logic signed [CW:0] mid;
   logic [1:0]    status_ff, status_in;
   logic [EW-1:0] oent_ff, oent_in;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [EW-1:0] ram_wd, ram_rd;
   logic          div_start, div_done;
   logic [CW-1:0] div_rem;
   logic [71:0]   rsp_ff;
   logic          rsp_valid_ff;
   logic signed [KEY_BITS-1:0] pkey, nkey;

   sai_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_table (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   sai_mod #(.NUM_BITS(16), .DEN_BITS(CW)) u_mod (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(req_tdata[64:49]), .denom(count_ff), .done(div_done), .remain(div_rem)
   );

   // clamp the capacity register into 1..DEPTH
   always_comb begin
      if (capacity_ff == 9'd0) begin
         cap = CW'(1);
      end else if (16'(capacity_ff) > 16'(DEPTH)) begin
         cap = CW'(DEPTH);
      end else begin
         cap = CW'(capacity_ff);
      end
   end

   assign mid  = low_ff + ((high_ff - low_ff) >>> 1);
   assign pkey = ram_rd[KEY_BITS-1:0];
   assign nkey = key_ff;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = req_tdata[0] == KIND_READ ? ST_RD_WAIT : ST_EV_DIV;
            end
         end
         ST_RD_WAIT:  state_in = ST_DONE;
         ST_EV_DIV: begin
            if (!(count_ff >= cap && count_ff != '0)) begin
               state_in = ST_SRCH_RD;
            end else if (div_done && !div_start) begin
               state_in = ST_EV_RD;
            end
         end
         ST_EV_RD:    state_in = ST_EV_SHIFT;
         ST_EV_SHIFT: state_in = (idx_ff + 1'b1 < count_ff) ? ST_EV_WR : ST_SRCH_RD;
         ST_EV_WR:    state_in = ST_EV_SHIFT;
         ST_SRCH_RD:  state_in = (low_ff <= high_ff) ? ST_SRCH_CMP : ST_INS_RD;
         ST_SRCH_CMP: state_in = (pkey == nkey) ? ST_INS_RD : ST_SRCH_RD;
         ST_INS_RD:   state_in = (count_ff >= CW'(DEPTH)) ? ST_DONE :
                                 (idx_ff > pos_ff) ? ST_INS_WR : ST_DONE;
         ST_INS_WR:   state_in = ST_INS_RD;
         ST_DONE:     state_in = (!rsp_valid_ff || rsp_tready) ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      status_in = status_ff;
      oent_in   = oent_ff;
      ram_we    = 1'b0;
      ram_addr  = idx_ff[AW-1:0];
      ram_wd    = ram_rd;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ram_addr  = AW'(req_tdata[72:65]);
            status_in = STATUS_INSERTED;
            oent_in   = '0;
            div_start = req_tvalid && req_tready;
         end
         ST_RD_WAIT: begin
            if (16'(ridx_ff) < 16'(count_ff)) begin
               status_in = STATUS_READ;
               oent_in   = ram_rd;
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         ST_EV_DIV: begin
            idx_in   = div_rem;
            ram_addr = div_rem[AW-1:0];
            low_in   = '0;
            high_in  = (CW+1)'(count_ff) - 1'b1;
         end
         ST_EV_RD: begin
            oent_in   = ram_rd;
            status_in = STATUS_EVICTED;
         end
         ST_EV_SHIFT: begin
            // fetch the entry that moves down next
            ram_addr = AW'(idx_ff + 1'b1);
            if (!(idx_ff + 1'b1 < count_ff)) begin
               count_in = count_ff - 1'b1;
               low_in   = '0;
               high_in  = (CW+1)'(count_ff) - 2'd2;
            end
         end
         ST_EV_WR: begin
            ram_we   = 1'b1;
            ram_addr = idx_ff[AW-1:0];
            ram_wd   = ram_rd;
            idx_in   = idx_ff + 1'b1;
         end
         ST_SRCH_RD: begin
            ram_addr = mid[AW-1:0];
            pos_in   = CW'(low_ff);
            idx_in   = count_ff;
         end
         ST_SRCH_CMP: begin
            ram_addr = mid[AW-1:0];
            if (pkey == nkey) begin
               pos_in = CW'(mid);
            end else if (pkey < nkey) begin
               low_in = mid + 1'b1;
            end else begin
               high_in = mid - 1'b1;
            end
            ram_addr = AW'(count_ff - 1'b1);
         end
         ST_INS_RD: begin
            if (count_ff < CW'(DEPTH)) begin
               if (idx_ff > pos_ff) begin
                  ram_addr = AW'(idx_ff - 1'b1);
               end else begin
                  ram_we   = 1'b1;
                  ram_addr = pos_ff[AW-1:0];
                  ram_wd   = {id_ff, key_ff};
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_INS_WR: begin
            ram_we   = 1'b1;
            ram_addr = idx_ff[AW-1:0];
            ram_wd   = ram_rd;
            idx_in   = idx_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= 9'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         // take a configuration write
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         // present the result and drop it once taken
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tdata[0];
         key_ff  <= KEY_BITS'(req_tdata[32:1]);
         id_ff   <= HANDLE_BITS'(req_tdata[48:33]);
         ridx_ff <= req_tdata[72:65];
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_ff <= {5'd0, 16'(oent_ff[EW-1 -: HANDLE_BITS]), 32'(oent_ff[KEY_BITS-1:0]),
                    9'(count_ff), (kind_ff == KIND_READ) ? ridx_ff : 8'(pos_ff),
                    status_ff};
      end
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      status_ff <= status_in;
      oent_ff   <= oent_in;
   end
endmodule
`default_nettype wire

[sv/sai_ram.sv]
// ----------------------------------------------------------------------------
// sai_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sai_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write the addressed entry when enabled; always read its old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[sv/sai_mod.sv]
// ----------------------------------------------------------------------------
// sai_mod
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sai_mod #(
   parameter int NUM_BITS = 16,
   parameter int DEN_BITS = 13
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numer,
   input  wire logic [DEN_BITS-1:0] denom,
   output      logic                done,
   output      logic [DEN_BITS-1:0] remain
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS:0]   rem_ff, rem_in, trial;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;

   // shift in one numerator bit and subtract when it fits
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[DEN_BITS-1:0], num_ff[NUM_BITS-1]};
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = (trial >= {1'b0, denom}) ? trial - {1'b0, denom} : trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done   = !busy_ff;
   assign remain = rem_ff[DEN_BITS-1:0];
endmodule
`default_nettype wire

[sv/sai_checker.sv]
// ----------------------------------------------------------------------------
// sai_checker
// Port-level checks for the sorted archive insert block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_archive_insert_macros.svh"
module sai_checker
   import sai_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   logic req_take, rsp_wait, rsp_plain;

   // name the handshake conditions once
   assign req_take  = req_tvalid && req_tready;
   assign rsp_wait  = rsp_tvalid && !rsp_tready;
   assign rsp_plain = rsp_tvalid && (rsp_tdata[1:0] == STATUS_INSERTED);

   `SAI_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `SAI_ASSERT_NEXT(a_one_at_a_time, req_take, !req_tready, "second request taken while busy")
   `SAI_ASSERT_IMPL(a_count_range, rsp_tvalid, rsp_tdata[18:10] <= 9'd256, "count above depth")
   `SAI_ASSERT_IMPL(a_plain_zero, rsp_plain, rsp_tdata[66:19] == '0, "plain insert carries data")
endmodule
bind sorted_archive_insert sai_checker u_sai_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
